[hdl/min_max_normalizer_unit_defines.svh]
// Assertion macros shared by the min-max normalizer RTL.
`ifndef MIN_MAX_NORMALIZER_UNIT_DEFINES_SVH
`define MIN_MAX_NORMALIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define MMN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MMN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define MMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/mmn_pkg.sv]
// Types and constants of the min-max normalizer.
package mmn_pkg;

	localparam int BLOCK_DEPTH = 64;
	localparam int STORE_SLOTS = 64;
	localparam int IDX_W       = $clog2(STORE_SLOTS);
	localparam int FILL_W      = $clog2(BLOCK_DEPTH + 1);
	localparam int SAMPLE_W    = 16;
	localparam int NORM_W      = 17;
	localparam int QUO_BITS    = NORM_W;
	localparam int CNT_W       = $clog2(QUO_BITS + 1);
	localparam logic [NORM_W-1:0] Q_ONE = NORM_W'(65536);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_START,
		S_DIV,
		S_PUSH
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[hdl/mmn_in_if.sv]
// Input stream interface: one signed sample and its end-of-block flag per transfer.
interface mmn_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [mmn_pkg::SAMPLE_W-1:0] sample;
	logic                                is_last;

	modport source (output valid, output sample, output is_last, input ready);
	modport sink (input valid, input sample, input is_last, output ready);
endinterface

[hdl/mmn_out_if.sv]
// Output stream interface: one normalized value and its end-of-block flag per transfer.
interface mmn_out_if;
	logic                        valid;
	logic                        ready;
	logic [mmn_pkg::NORM_W-1:0]  norm_value;
	logic                        last_out;

	modport source (output valid, output norm_value, output last_out, input ready);
	modport sink (input valid, input norm_value, input last_out, output ready);
endinterface

[hdl/mmn_div.sv]
// Restoring divider producing the Q1.16 quotient dividend * 65536 / divisor, one bit per cycle.
`include "min_max_normalizer_unit_defines.svh"

module mmn_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mmn_pkg::div_ctrl_t                  ctrl,
	input  logic [mmn_pkg::SAMPLE_W-1:0]        dividend,
	input  logic [mmn_pkg::SAMPLE_W-1:0]        divisor,
	output mmn_pkg::div_stat_t                  stat,
	output logic [mmn_pkg::NORM_W-1:0]          quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic                             first_q;
	logic [mmn_pkg::CNT_W-1:0]        cnt_q;
	logic [mmn_pkg::SAMPLE_W:0]       rem_q;
	logic [mmn_pkg::SAMPLE_W-1:0]     dsr_q;
	logic [mmn_pkg::NORM_W-1:0]       quo_q;

	logic [mmn_pkg::SAMPLE_W:0]       cand;
	logic                             ge;
	logic [mmn_pkg::SAMPLE_W:0]       rem_nxt;

	// The first step takes the integer bit without a shift; the remainder stays
	// below the divisor afterwards, so the doubled value always fits.
	always_comb begin
		cand    = first_q ? rem_q : {rem_q[mmn_pkg::SAMPLE_W-1:0], 1'b0};
		ge      = cand >= {1'b0, dsr_q};
		rem_nxt = ge ? (cand - {1'b0, dsr_q}) : cand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start && !busy_q) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= mmn_pkg::CNT_W'(mmn_pkg::QUO_BITS);
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q - 1'b1;
				if (cnt_q == mmn_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start && !busy_q) begin
			rem_q <= {1'b0, dividend};
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[mmn_pkg::NORM_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	`MMN_ASSERT_NOW(a_div_done_idle, clk, arst_n, done_q, !busy_q, "divider done while busy")
	`MMN_ASSERT_NOW(a_div_cnt_range, clk, arst_n, busy_q,
		(cnt_q != '0) && (cnt_q <= mmn_pkg::CNT_W'(mmn_pkg::QUO_BITS)), "divider count out of range")
	`MMN_ASSERT_NEXT(a_div_start_busy, clk, arst_n, ctrl.start && !busy_q, busy_q && first_q,
		"divider did not start")

endmodule

[hdl/min_max_normalizer_unit.sv]
// Min-max normalizer: buffers a block of samples and emits each as a Q1.16 fraction.
// Usage:
// The samples channel takes one signed 16-bit sample per transfer. The sample store
// keeps the block in arrival order while the running minimum and maximum follow it.
// A transfer with is_last set, or the one that fills the store to BLOCK_DEPTH
// entries, ends the block. The unit then stops taking samples and emits, on the
// results channel, one value (x - min) * 65536 / (max - min) per stored sample, in
// order, truncated, from 0 to 65536. The final value of the block carries last_out.
// If every sample of the block is equal the divisor is zero and each value is 0.
// Timing: in the idle state a sample that does not end a block is taken as soon
// as it is offered. Each result passes through a memory read, a setup state, the
// shared restoring divider (one quotient bit per cycle), its done flag and the
// load of the output register. The next block can start in the cycle after the
// last result is loaded.
// A stalled receiver holds the output register; the unit waits with the next
// quotient ready and loses nothing. Reset clears the control state, the fill count
// and the running minimum and maximum; the store needs no clearing since only
// entries written in the current block are read.
`include "min_max_normalizer_unit_defines.svh"

module min_max_normalizer_unit (
	input logic       clk,
	input logic       arst_n,
	mmn_in_if.sink    samples,
	mmn_out_if.source results
);

	mmn_pkg::state_t state_q, state_nxt;

	// Block bookkeeping.
	logic [mmn_pkg::FILL_W-1:0]          fill_q;
	logic [mmn_pkg::FILL_W-1:0]          fill_nxt;
	logic [mmn_pkg::FILL_W-1:0]          count_q;
	logic [mmn_pkg::IDX_W-1:0]           idx_q;
	logic signed [mmn_pkg::SAMPLE_W-1:0] min_q;
	logic signed [mmn_pkg::SAMPLE_W-1:0] max_q;

	// Sample store, written on each sample transfer and read at the emit index.
	logic signed [mmn_pkg::SAMPLE_W-1:0] store_mem [mmn_pkg::STORE_SLOTS];
	logic signed [mmn_pkg::SAMPLE_W-1:0] rd_data_q;

	// Output register.
	logic                        out_valid_q;
	logic [mmn_pkg::NORM_W-1:0]  norm_q;
	logic                        last_q;

	// Divider link.
	mmn_pkg::div_ctrl_t          div_ctrl;
	mmn_pkg::div_stat_t          div_stat;
	logic [mmn_pkg::NORM_W-1:0]  div_quo;
	logic [mmn_pkg::SAMPLE_W:0]  span_wide;
	logic [mmn_pkg::SAMPLE_W:0]  diff_wide;
	logic [mmn_pkg::SAMPLE_W-1:0] span;
	logic [mmn_pkg::SAMPLE_W-1:0] diff;

	logic accept;
	logic end_blk;
	logic push;
	logic last_idx;

	assign accept   = samples.valid && samples.ready;
	assign fill_nxt = fill_q + 1'b1;
	assign end_blk  = samples.is_last || (fill_nxt == mmn_pkg::FILL_W'(mmn_pkg::BLOCK_DEPTH));
	assign last_idx = ({1'b0, idx_q} + 1'b1) == count_q;
	assign push     = (state_q == mmn_pkg::S_PUSH) && (!out_valid_q || results.ready);

	// Both differences are non-negative once the block has its minimum and maximum,
	// and they stay below 65536, so the low 16 bits carry them exactly.
	assign span_wide = {max_q[mmn_pkg::SAMPLE_W-1], max_q} - {min_q[mmn_pkg::SAMPLE_W-1], min_q};
	assign diff_wide = {rd_data_q[mmn_pkg::SAMPLE_W-1], rd_data_q}
		- {min_q[mmn_pkg::SAMPLE_W-1], min_q};
	assign span      = span_wide[mmn_pkg::SAMPLE_W-1:0];
	assign diff      = diff_wide[mmn_pkg::SAMPLE_W-1:0];

	// Next-state logic of the emit sequencer.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mmn_pkg::S_IDLE: begin
				if (accept && end_blk) state_nxt = mmn_pkg::S_READ;
			end
			mmn_pkg::S_READ:  state_nxt = mmn_pkg::S_START;
			mmn_pkg::S_START: state_nxt = mmn_pkg::S_DIV;
			mmn_pkg::S_DIV: begin
				if (div_stat.done) state_nxt = mmn_pkg::S_PUSH;
			end
			mmn_pkg::S_PUSH: begin
				if (push) state_nxt = last_idx ? mmn_pkg::S_IDLE : mmn_pkg::S_READ;
			end
			default: state_nxt = mmn_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		samples.ready  = 1'b0;
		div_ctrl.start = 1'b0;
		unique case (state_q) inside
			mmn_pkg::S_IDLE:  samples.ready  = 1'b1;
			mmn_pkg::S_START: div_ctrl.start = 1'b1;
			mmn_pkg::S_READ, mmn_pkg::S_DIV, mmn_pkg::S_PUSH: begin
				samples.ready  = 1'b0;
				div_ctrl.start = 1'b0;
			end
			default: begin
				samples.ready  = 1'b0;
				div_ctrl.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mmn_pkg::S_IDLE;
			fill_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				// The first sample of a block seeds both extremes.
				if (fill_q == '0) begin
					min_q <= samples.sample;
					max_q <= samples.sample;
				end else begin
					if (samples.sample < min_q) min_q <= samples.sample;
					if (samples.sample > max_q) max_q <= samples.sample;
				end
				if (end_blk) begin
					fill_q  <= '0;
					count_q <= fill_nxt;
					idx_q   <= '0;
				end else begin
					fill_q <= fill_nxt;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) store_mem[fill_q[mmn_pkg::IDX_W-1:0]] <= samples.sample;
		rd_data_q <= store_mem[idx_q];
	end

	// A zero span means all samples were equal; the quotient is then forced to 0.
	always_ff @(posedge clk) begin
		if (push) begin
			norm_q <= (span == '0) ? '0 : div_quo;
			last_q <= last_idx;
		end
	end

	mmn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (diff),
		.divisor  (span),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign results.valid      = out_valid_q;
	assign results.norm_value = norm_q;
	assign results.last_out   = last_q;

	`MMN_ASSERT_NEXT(a_block_end_stops_input, clk, arst_n, accept && end_blk, !samples.ready,
		"sample taken right after the end of a block")
	`MMN_ASSERT_NOW(a_norm_range, clk, arst_n, results.valid, results.norm_value <= mmn_pkg::Q_ONE,
		"normalized value above 1.0")
	`MMN_ASSERT_NOW(a_fill_range, clk, arst_n, 1'b1,
		fill_q < mmn_pkg::FILL_W'(mmn_pkg::BLOCK_DEPTH), "fill count reached the block depth")
	`MMN_ASSERT_NOW(a_start_free, clk, arst_n, div_ctrl.start, !div_stat.busy,
		"divider started while busy")
	`MMN_ASSERT_NOW(a_emit_index, clk, arst_n, state_q != mmn_pkg::S_IDLE,
		{1'b0, idx_q} < count_q, "emit index beyond the block")

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for min_max_normalizer_unit: random blocks of samples, checked values.
`timescale 1ns / 1ps

module tb;

	typedef logic signed [mmn_pkg::SAMPLE_W-1:0] sample_t;

	// One pending input transfer. The drain flag makes the sender wait before
	// this sample until every normalized value of earlier blocks has arrived.
	typedef struct {
		sample_t sample;
		logic    is_last;
		bit      drain_first;
	} sample_item_t;

	// One normalized value as the unit should emit it.
	typedef struct {
		logic [mmn_pkg::NORM_W-1:0] norm;
		logic                       last;
	} norm_value_t;

	// The longest stretch without any transfer that a correct run can show is
	// the long receiver hold-off plus one divider pass; this is several times that.
	localparam int IDLE_LIMIT     = 3000;
	localparam int LONG_HOLD      = 400;
	localparam int RANDOM_SAMPLES = 312;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mmn_in_if  in_ch ();
	mmn_out_if out_ch ();

	min_max_normalizer_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (in_ch),
		.results (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Samples still to be sent, and normalized values still to be received.
	sample_item_t sample_queue[$];
	norm_value_t  norm_expect[$];

	// The testbench's own copy of the block state: the samples of the current
	// block, their running extremes and how many have been stored.
	sample_t blk_store[mmn_pkg::BLOCK_DEPTH];
	sample_t blk_min;
	sample_t blk_max;
	int      blk_fill = 0;

	int fail_count     = 0;
	int samples_sent   = 0;
	int values_checked = 0;
	int blocks_done    = 0;
	int full_blocks    = 0;
	int flat_blocks    = 0;

	// Takes one accepted sample into the block. When the sample ends the block,
	// either by its flag or by filling the store, the expected normalized value
	// of every stored sample is queued in arrival order, the last one flagged.
	function automatic void absorb_sample(sample_t x, logic ends_block);
		int          span;
		longint      scaled;
		norm_value_t v;
		if (blk_fill >= mmn_pkg::BLOCK_DEPTH)
			blk_fill = 0;
		if (blk_fill == 0) begin
			blk_min = x;
			blk_max = x;
		end else begin
			if (x < blk_min)
				blk_min = x;
			if (x > blk_max)
				blk_max = x;
		end
		blk_store[blk_fill] = x;
		blk_fill++;
		if (!ends_block && blk_fill < mmn_pkg::BLOCK_DEPTH)
			return;
		// The span is at most 65535, so the scaled offset stays below 2^32 and
		// the truncated quotient never exceeds 65536.
		span = int'(blk_max) - int'(blk_min);
		for (int i = 0; i < blk_fill; i++) begin
			scaled = longint'(int'(blk_store[i]) - int'(blk_min)) * 65536;
			v.norm = (span == 0) ? '0 : mmn_pkg::NORM_W'(scaled / span);
			v.last = (i == blk_fill - 1);
			norm_expect.push_back(v);
		end
		blocks_done++;
		if (!ends_block)
			full_blocks++;
		if (span == 0)
			flat_blocks++;
		blk_fill = 0;
	endfunction

	function automatic void queue_sample(sample_t x, logic ends_block, bit drain = 1'b0);
		sample_item_t it;
		it.sample      = x;
		it.is_last     = ends_block;
		it.drain_first = drain;
		sample_queue.push_back(it);
	endfunction

	// ------------------------------------------------------------------
	// Sender. It offers samples in bursts of random length separated by
	// random gaps. Once valid is raised it stays up with the same sample
	// until the transfer happens, and every input gets exactly one
	// nonblocking assignment per edge.
	// ------------------------------------------------------------------
	sample_item_t cur_item;
	bit           offer_now;
	int           burst_left = 1;
	int           gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.sample  <= '0;
			in_ch.is_last <= 1'b0;
		end else begin
			offer_now = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				absorb_sample(cur_item.sample, cur_item.is_last);
				samples_sent++;
				offer_now = 1'b0;
			end
			if (!offer_now) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (sample_queue.size() != 0 &&
						(!sample_queue[0].drain_first || norm_expect.size() == 0)) begin
					cur_item  = sample_queue.pop_front();
					offer_now = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						// Some bursts run back to back so that there are
						// long stretches with no idle cycle at all.
						burst_left = $urandom_range(1, 20);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			in_ch.valid   <= offer_now;
			in_ch.sample  <= cur_item.sample;
			in_ch.is_last <= cur_item.is_last;
		end
	end

	// ------------------------------------------------------------------
	// Receiver and checker. Every accepted value is compared with the
	// oldest expectation. Ready follows phases of its own: always ready,
	// randomly choppy, or runs of stalls. Once in the run it holds off for a
	// long stretch so that the unit has to keep its output register and
	// stop taking samples.
	// ------------------------------------------------------------------
	norm_value_t want;
	bit          take_now;
	bit          long_hold_done = 1'b0;
	int          hold_left      = 0;
	int          phase_left     = 0;
	int          phase_mode     = 0;
	int          stall_left     = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (norm_expect.size() == 0) begin
					$error("unexpected transfer: norm_value %0d last_out %0b",
						out_ch.norm_value, out_ch.last_out);
					fail_count++;
				end else begin
					want = norm_expect.pop_front();
					if (out_ch.norm_value !== want.norm) begin
						$error("norm_value mismatch: expected %0d, actual %0d",
							want.norm, out_ch.norm_value);
						fail_count++;
					end
					if (out_ch.last_out !== want.last) begin
						$error("last_out mismatch: expected %0b, actual %0b",
							want.last, out_ch.last_out);
						fail_count++;
					end
				end
				values_checked++;
			end

			if (!long_hold_done && values_checked >= 20) begin
				hold_left      = LONG_HOLD;
				long_hold_done = 1'b1;
			end

			if (hold_left > 0) begin
				hold_left--;
				take_now = 1'b0;
			end else begin
				if (phase_left == 0) begin
					phase_mode = $urandom_range(0, 2);
					phase_left = $urandom_range(10, 60);
				end
				phase_left--;
				case (phase_mode)
					0: begin
						take_now = 1'b1;
					end
					1: begin
						take_now = ($urandom_range(0, 2) != 0);
					end
					default: begin
						if (stall_left > 0) begin
							stall_left--;
							take_now = 1'b0;
						end else begin
							take_now = 1'b1;
							if ($urandom_range(0, 5) == 0)
								stall_left = $urandom_range(1, 10);
						end
					end
				endcase
			end
			out_ch.ready <= take_now;
		end
	end

	// Watchdog: ends the run if no transfer happens on either side for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d values still expected",
				IDLE_LIMIT, norm_expect.size());
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------
	initial begin
		int      blk_count;
		int      blk_len;
		int      style;
		int      base;
		sample_t x;
		logic    ends_block;

		// Directed blocks. A lone sample has a zero span and gives 0.
		queue_sample(16'sh7FFF, 1'b1);
		queue_sample(16'sh8000, 1'b1);
		// Both extremes: the minimum maps to 0 and the maximum to 1.0.
		queue_sample(16'sh8000, 1'b0);
		queue_sample(16'sh7FFF, 1'b1);
		// Full span with values near the middle, maximum arriving first.
		queue_sample(16'sh7FFF, 1'b0);
		queue_sample(16'sh8000, 1'b0);
		queue_sample(16'sh0000, 1'b0);
		queue_sample(-16'sd1, 1'b0);
		queue_sample(16'sd1, 1'b1);
		// All samples equal: the divisor is zero and every value is 0.
		queue_sample(-16'sd5, 1'b0);
		queue_sample(-16'sd5, 1'b0);
		queue_sample(-16'sd5, 1'b1);
		// Span of one, and a small span with truncated thirds.
		queue_sample(16'sd0, 1'b0);
		queue_sample(16'sd1, 1'b1);
		queue_sample(16'sd100, 1'b0);
		queue_sample(16'sd99, 1'b0);
		queue_sample(16'sd101, 1'b0);
		queue_sample(16'sd102, 1'b1);

		// Random blocks. The first fills the store without a last flag, so the
		// store-full rule ends it; the second is full and flagged as well. Most
		// others are short, a few are long, and now and then the sender waits
		// for the unit to drain before it starts a block.
		blk_count = 0;
		while (sample_queue.size() < RANDOM_SAMPLES + 18) begin
			if (blk_count < 2) begin
				blk_len = mmn_pkg::BLOCK_DEPTH;
			end else begin
				case ($urandom_range(0, 9))
					0:       blk_len = $urandom_range(33, mmn_pkg::BLOCK_DEPTH);
					1:       blk_len = 2;
					default: blk_len = $urandom_range(1, 10);
				endcase
			end
			style = $urandom_range(0, 5);
			base  = int'($urandom_range(0, 65535 - 16)) - 32768;
			for (int k = 0; k < blk_len; k++) begin
				case (style)
					0, 1: begin
						x = sample_t'($urandom_range(0, 65535));
					end
					2: begin
						x = sample_t'(base + int'($urandom_range(0, 15)));
					end
					3: begin
						case ($urandom_range(0, 3))
							0:       x = 16'sh8000;
							1:       x = 16'sh7FFF;
							2:       x = -16'sd1;
							default: x = sample_t'($urandom_range(0, 65535));
						endcase
					end
					4: begin
						x = sample_t'(base);
					end
					default: begin
						x = sample_t'(base + int'($urandom_range(0, 3)));
					end
				endcase
				if (k != blk_len - 1)
					ends_block = 1'b0;
				else if (blk_len == mmn_pkg::BLOCK_DEPTH)
					ends_block = (blk_count == 0) ? 1'b0 :
						(blk_count == 1) ? 1'b1 : 1'($urandom_range(0, 1));
				else
					ends_block = 1'b1;
				queue_sample(x, ends_block, (k == 0) && (blk_count % 7 == 3));
			end
			blk_count++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// All samples sent, then every expected value received, then a further wait
		// so that a stray extra value would be caught.
		do
			@(posedge clk);
		while (sample_queue.size() != 0 || in_ch.valid);
		while (norm_expect.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Covered %0d samples in %0d blocks (%0d ended by a full store, %0d flat).",
			samples_sent, blocks_done, full_blocks, flat_blocks);
		$display("Checked %0d normalized values with random stalls on both channels.",
			values_checked);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/mmn_pkg.sv
hdl/mmn_in_if.sv
hdl/mmn_out_if.sv
hdl/mmn_div.sv
hdl/min_max_normalizer_unit.sv
tb/sv/tb.sv
